// ===== rtl/mclbr_pkg.sv =====
// Package: types and constants of the LED breathing ramp core
package mclbr_pkg;

    localparam int unsigned CHANNELS_DEF = 8;
    localparam int unsigned PERIOD_RESET = 10;
    localparam int unsigned DUTY_MAX     = 100;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_START = 2'd1,
        CMD_STOP  = 2'd2,
        CMD_FORCE = 2'd3
    } cmd_t;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [2:0]  channel;
        logic [15:0] level_begin;
        logic [15:0] level_end;
        logic [15:0] interval_ms;
        logic [7:0]  rise_pct;
        logic        half_end;
        logic [15:0] force_level;
    } item_in_t;

    typedef struct packed {
        logic [2:0]  out_channel;
        logic [15:0] pulse;
        logic        last;
        logic        all_idle;
    } item_out_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV1,
        ST_MUL,
        ST_DIV2,
        ST_SETUP,
        ST_DIV3,
        ST_DIV4,
        ST_WRITE,
        ST_SCAN,
        ST_EMIT
    } state_t;

    // control between sequencer and bit-serial divider
    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [15:0] divisor;
    } div_req_t;

endpackage

// ===== rtl/mclbr_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle
module mclbr_div (
    input  logic                  clk,
    input  logic                  rst_n,
    input  mclbr_pkg::div_req_t   req,
    output logic                  done,
    output logic [31:0]           quotient
);
    import mclbr_pkg::*;

    logic [31:0] quo_reg, quo_next;
    logic [16:0] rem_reg, rem_next;
    logic [15:0] dvs_reg, dvs_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [16:0] trial;
    logic        take;
    logic [31:0] quo_step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial     = {rem_reg[15:0], quo_reg[31]};
        take      = (trial >= {1'b0, dvs_reg});
        quo_step  = {quo_reg[30:0], take};
        if (req.start)
        begin
            quo_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
            cnt_next  = 6'd32;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quo_next = quo_step;
            if (take)
                rem_next = trial - {1'b0, dvs_reg};
            else
                rem_next = trial;
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
                busy_next = 1'b0;
        end
    end

    // final quotient stays valid in the done cycle even if a new divide is started then
    assign done     = busy_reg && (cnt_reg == 6'd1);
    assign quotient = busy_reg ? quo_step : quo_reg;

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (cnt_reg != 6'd0 && cnt_reg <= 6'd32))
        else $error("divider count out of range");
    a_done_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !req.start) |=> !busy_reg)
        else $error("divider busy after done");
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |=> busy_reg)
        else $error("divider not busy after start");

endmodule

// ===== rtl/multi_channel_led_breath_ramp_core.sv =====
// Top level: per-channel LED breathing ramps with PWM level output
// An item is taken when start is high and busy is low; one item is worked on at a time.
// A tick scans the channels one per cycle and emits each active channel's result as the scan
// passes it; busy falls after the highest active channel, or after the full scan when none is
// active. A start runs four divisions on one shared bit-serial divider and a serial shift-add
// duty multiply, and gives no result. Stop and fast set hold busy through the emit state and
// give their result in the cycle after they are taken. Results come out one per cycle on
// result_valid and the receiver cannot stall them. Channel state sits in registers, one entry
// per channel.
module multi_channel_led_breath_ramp_core #(
    parameter int unsigned CHANNELS = mclbr_pkg::CHANNELS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  mclbr_pkg::item_in_t   item,
    output logic                  result_valid,
    output mclbr_pkg::item_out_t  result,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [9:0]            cfg_data
);
    import mclbr_pkg::*;

    localparam int unsigned CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    // index counter also steps the serial duty multiply
    localparam int unsigned IW = (CW > 3) ? CW : 3;

    state_t state_reg, state_next;
    logic [9:0] period_reg;

    logic [CHANNELS-1:0] active_reg, rising_reg, hold_reg;
    logic [15:0] beg_reg  [CHANNELS];
    logic [15:0] end_reg  [CHANNELS];
    logic [15:0] now_reg  [CHANNELS];
    logic [7:0]  rcnt_reg [CHANNELS];
    logic [7:0]  rtot_reg [CHANNELS];
    logic [16:0] rdel_reg [CHANNELS];
    logic [7:0]  fcnt_reg [CHANNELS];
    logic [7:0]  ftot_reg [CHANNELS];
    logic [16:0] fdel_reg [CHANNELS];

    item_in_t    cur_reg;
    logic [IW:0] idx_reg, idx_next;
    logic [31:0] acc_reg, acc_next;     // serial multiply accumulator
    logic [31:0] tot_reg, tot_next;
    logic [7:0]  mb_reg, mb_next;       // duty multiplier bits
    logic [31:0] fwd_reg, fwd_next;
    logic [7:0]  rt_reg, rt_next, ft_reg, ft_next;
    logic [16:0] rd_reg, rd_next;
    logic        rneg_reg, rneg_next;
    logic [15:0] mag_reg, mag_next;

    item_out_t   out_reg, out_next;
    logic        outv_reg, outv_next;

    div_req_t    dreq;
    logic        ddone;
    logic [31:0] dq;

    // tick scan controls
    logic        sel_ok;
    logic [CW-1:0] ci;
    logic [CW-1:0] cur_ch;
    logic [CW-1:0] in_ch;
    logic        upd;
    logic        wr_start;
    logic [16:0] fd_val;
    logic [CHANNELS-1:0] act_after;

    mclbr_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (dreq),
        .done     (ddone),
        .quotient (dq)
    );

    assign ci     = idx_reg[CW-1:0];
    assign cur_ch = CW'(cur_reg.channel);
    assign in_ch  = CW'(item.channel);
    assign sel_ok = (32'(idx_reg) < 32'(CHANNELS));
    assign busy   = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;
    assign result_valid = outv_reg;
    assign result = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            period_reg <= 10'(PERIOD_RESET);
            outv_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            outv_reg  <= outv_next;
            if (cfg_valid && cfg_ready)
                period_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
            cur_reg <= item;
        idx_reg <= idx_next;
        acc_reg <= acc_next;
        tot_reg <= tot_next;
        mb_reg  <= mb_next;
        fwd_reg <= fwd_next;
        rt_reg  <= rt_next;
        ft_reg  <= ft_next;
        rd_reg  <= rd_next;
        rneg_reg <= rneg_next;
        mag_reg <= mag_next;
        out_reg <= out_next;
    end

    // per-channel state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= '0;
            rising_reg <= '0;
            hold_reg   <= '0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                beg_reg[i]  <= '0;
                end_reg[i]  <= '0;
                now_reg[i]  <= '0;
                rcnt_reg[i] <= '0;
                rtot_reg[i] <= '0;
                rdel_reg[i] <= '0;
                fcnt_reg[i] <= '0;
                ftot_reg[i] <= '0;
                fdel_reg[i] <= '0;
            end
        end
        else if (wr_start)
        begin
            active_reg[cur_ch] <= 1'b1;
            rising_reg[cur_ch] <= 1'b1;
            hold_reg[cur_ch]   <= cur_reg.half_end;
            beg_reg[cur_ch]    <= cur_reg.level_begin;
            end_reg[cur_ch]    <= cur_reg.level_end;
            now_reg[cur_ch]    <= cur_reg.level_begin;
            rcnt_reg[cur_ch]   <= '0;
            fcnt_reg[cur_ch]   <= '0;
            rtot_reg[cur_ch]   <= rt_reg;
            ftot_reg[cur_ch]   <= ft_reg;
            rdel_reg[cur_ch]   <= rd_reg;
            // empty falling phase gets a zero step
            fdel_reg[cur_ch]   <= (ft_reg == 8'd0) ? 17'd0 : fd_val;
        end
        else if (state_reg == ST_IDLE && start && item.cmd != CMD_TICK
                 && item.cmd != CMD_START
                 && {29'd0, item.channel} < 32'(CHANNELS))
        begin
            active_reg[in_ch] <= 1'b0;
        end
        else if (upd)
        begin
            if (rising_reg[ci])
            begin
                if (rcnt_reg[ci] >= rtot_reg[ci])
                begin
                    now_reg[ci]    <= end_reg[ci];
                    fcnt_reg[ci]   <= '0;
                    rising_reg[ci] <= 1'b0;
                end
                else
                begin
                    rcnt_reg[ci] <= rcnt_reg[ci] + 8'd1;
                    now_reg[ci]  <= now_reg[ci] + rdel_reg[ci][15:0];
                end
            end
            else
            begin
                if (fcnt_reg[ci] >= ftot_reg[ci])
                begin
                    now_reg[ci]    <= beg_reg[ci];
                    rcnt_reg[ci]   <= '0;
                    rising_reg[ci] <= 1'b1;
                end
                else
                begin
                    fcnt_reg[ci] <= fcnt_reg[ci] + 8'd1;
                    now_reg[ci]  <= now_reg[ci] + fdel_reg[ci][15:0];
                end
            end
        end
    end

    // signed quotient from magnitude of the divide
    assign fd_val = rneg_reg ? 17'(-{1'b0, dq[15:0]}) : {1'b0, dq[15:0]};

    always_comb
    begin
        logic        found;
        logic [16:0] span;
        state_next = state_reg;
        idx_next   = idx_reg;
        acc_next   = acc_reg;
        tot_next   = tot_reg;
        mb_next    = mb_reg;
        fwd_next   = fwd_reg;
        rt_next    = rt_reg;
        ft_next    = ft_reg;
        rd_next    = rd_reg;
        rneg_next  = rneg_reg;
        mag_next   = mag_reg;
        out_next   = out_reg;
        outv_next  = 1'b0;
        dreq       = '0;
        upd        = 1'b0;
        wr_start   = 1'b0;
        found      = 1'b0;
        span       = '0;
        act_after  = active_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    case (item.cmd)
                        CMD_TICK:
                        begin
                            idx_next   = '0;
                            state_next = ST_SCAN;
                        end
                        CMD_START:
                        begin
                            if ({29'd0, item.channel} < 32'(CHANNELS))
                            begin
                                dreq.start    = 1'b1;
                                dreq.dividend = {16'd0, item.interval_ms};
                                dreq.divisor  = (period_reg == 10'd0) ? 16'd1
                                                : {6'd0, period_reg};
                                state_next    = ST_DIV1;
                            end
                        end
                        default:
                        begin
                            if ({29'd0, item.channel} < 32'(CHANNELS))
                            begin
                                act_after = active_reg;
                                act_after[in_ch] = 1'b0;
                                out_next.out_channel = item.channel;
                                out_next.pulse = (item.cmd == CMD_FORCE)
                                    ? item.force_level
                                    : (hold_reg[in_ch] ? end_reg[in_ch] : beg_reg[in_ch]);
                                out_next.last     = 1'b1;
                                out_next.all_idle = (act_after == '0);
                                outv_next  = 1'b1;
                                state_next = ST_EMIT;
                            end
                        end
                    endcase
                end
            end
            ST_DIV1:
            begin
                if (ddone)
                begin
                    tot_next = (dq == 32'd0) ? 32'd1 : dq;
                    mb_next  = (cur_reg.rise_pct > 8'(DUTY_MAX))
                               ? 8'(DUTY_MAX) : cur_reg.rise_pct;
                    acc_next = '0;
                    idx_next = '0;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                // shift-add, one duty bit a cycle
                acc_next = mb_reg[7] ? ({acc_reg[30:0], 1'b0} + tot_reg)
                                     : {acc_reg[30:0], 1'b0};
                mb_next  = {mb_reg[6:0], 1'b0};
                idx_next = idx_reg + 1'b1;
                if (idx_reg == (IW+1)'(7))
                begin
                    dreq.start    = 1'b1;
                    dreq.dividend = acc_next;
                    dreq.divisor  = 16'(DUTY_MAX);
                    state_next    = ST_DIV2;
                end
            end
            ST_DIV2:
            begin
                if (ddone)
                begin
                    fwd_next = dq;
                    rt_next  = (dq > 32'd255) ? 8'd255 : dq[7:0];
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                tot_next = tot_reg - fwd_reg;
                ft_next  = ((tot_reg - fwd_reg) > 32'd255) ? 8'd255
                           : 8'(tot_reg - fwd_reg);
                span     = {1'b0, cur_reg.level_end} - {1'b0, cur_reg.level_begin};
                rneg_next = span[16];
                mag_next  = span[16] ? 16'(-span) : span[15:0];
                dreq.start    = 1'b1;
                dreq.dividend = {16'd0, mag_next};
                dreq.divisor  = (rt_reg == 8'd0) ? 16'd1 : {8'd0, rt_reg};
                state_next    = ST_DIV3;
            end
            ST_DIV3:
            begin
                if (ddone)
                begin
                    rd_next = (rt_reg == 8'd0) ? 17'd0 : fd_val;
                    rneg_next = ~rneg_reg;
                    dreq.start    = 1'b1;
                    dreq.dividend = {16'd0, mag_reg};
                    dreq.divisor  = (ft_reg == 8'd0) ? 16'd1 : {8'd0, ft_reg};
                    state_next    = ST_DIV4;
                end
            end
            ST_DIV4:
            begin
                if (ddone)
                    state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                // fall delta is taken from the held divider quotient through fd_val
                wr_start   = 1'b1;
                state_next = ST_IDLE;
            end
            ST_SCAN:
            begin
                if (!sel_ok)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                    if (active_reg[ci])
                    begin
                        upd = 1'b1;
                        out_next.out_channel = 3'(ci);
                        if (rising_reg[ci])
                            out_next.pulse = (rcnt_reg[ci] >= rtot_reg[ci])
                                             ? end_reg[ci] : now_reg[ci];
                        else
                            out_next.pulse = (fcnt_reg[ci] >= ftot_reg[ci])
                                             ? beg_reg[ci] : now_reg[ci];
                        out_next.all_idle = 1'b0;
                        found = 1'b0;
                        for (int j = 0; j < CHANNELS; j++)
                            if (j > ci && active_reg[j])
                                found = 1'b1;
                        out_next.last = !found;
                        outv_next = 1'b1;
                        if (!found)
                            state_next = ST_IDLE;
                    end
                end
            end
            ST_EMIT:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_one_start: assert property (@(posedge clk) disable iff (!rst_n)
        wr_start |=> (state_reg == ST_IDLE))
        else $error("start write did not return to idle");
    a_res_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.all_idle) |-> (active_reg != '0))
        else $error("all_idle low with no active channel");
    a_last_free: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.last) |-> (state_reg == ST_IDLE || state_reg == ST_EMIT))
        else $error("last result while still working");

endmodule

// ===== dv/tb_multi_channel_led_breath_ramp_core.sv =====
// Testbench for the LED breathing ramp core: directed and random commands checked against a local predictor
`timescale 1ns / 100ps

module tb_multi_channel_led_breath_ramp_core;
    import mclbr_pkg::*;

    localparam int NCH = 8;
    localparam longint CYCLE_LIMIT = 400000;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    item_in_t item;
    logic result_valid;
    item_out_t result;
    logic cfg_valid;
    logic cfg_ready;
    logic [9:0] cfg_data;

    multi_channel_led_breath_ramp_core #(.CHANNELS(NCH)) u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .item(item),
        .result_valid(result_valid), .result(result),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    // ramp state per channel
    logic        ch_active [NCH];
    logic        ch_rising [NCH];
    logic [15:0] ch_begin [NCH];
    logic [15:0] ch_end [NCH];
    logic [15:0] ch_level [NCH];
    logic [7:0]  up_cnt [NCH];
    logic [7:0]  up_tot [NCH];
    logic signed [16:0] up_step [NCH];
    logic [7:0]  dn_cnt [NCH];
    logic [7:0]  dn_tot [NCH];
    logic signed [16:0] dn_step [NCH];
    logic        ch_hold_end [NCH];
    logic [9:0]  period_ms;

    item_in_t  pending_items[$];
    item_out_t expected_pulses[$];
    int errors;
    int items_sent;
    int pulses_seen;
    longint cycles;

    always #5 clk = ~clk;

    function automatic logic signed [16:0] step_of(int span, logic [7:0] n);
        if (n == 0)
            return 17'sd0;
        return 17'(span / int'(n));
    endfunction

    task automatic predict_item(input item_in_t it);
        item_out_t outs[$];
        item_out_t o;
        int unsigned total, fwd, rev, duty, per;
        bit idle;
        int c;
        begin
            c = it.channel;
            case (cmd_t'(it.cmd))
                CMD_TICK: begin
                    for (int k = 0; k < NCH; k++) begin
                        if (!ch_active[k])
                            continue;
                        o = '0;
                        o.out_channel = k[2:0];
                        if (ch_rising[k]) begin
                            if (up_cnt[k] >= up_tot[k]) begin
                                o.pulse = ch_end[k];
                                ch_level[k] = ch_end[k];
                                dn_cnt[k] = '0;
                                ch_rising[k] = 1'b0;
                            end
                            else begin
                                up_cnt[k]++;
                                o.pulse = ch_level[k];
                                ch_level[k] = ch_level[k] + up_step[k][15:0];
                            end
                        end
                        else begin
                            if (dn_cnt[k] >= dn_tot[k]) begin
                                o.pulse = ch_begin[k];
                                ch_level[k] = ch_begin[k];
                                up_cnt[k] = '0;
                                ch_rising[k] = 1'b1;
                            end
                            else begin
                                o.pulse = ch_level[k];
                                ch_level[k] = ch_level[k] + dn_step[k][15:0];
                                dn_cnt[k]++;
                            end
                        end
                        outs.push_back(o);
                    end
                end
                CMD_START: begin
                    per = (period_ms == 0) ? 1 : period_ms;
                    total = it.interval_ms / per;
                    if (total == 0)
                        total = 1;
                    duty = (it.rise_pct > DUTY_MAX) ? DUTY_MAX : it.rise_pct;
                    fwd = total * duty / 100;
                    rev = total - fwd;
                    ch_active[c] = 1'b1;
                    ch_rising[c] = 1'b1;
                    ch_begin[c] = it.level_begin;
                    ch_end[c] = it.level_end;
                    ch_level[c] = it.level_begin;
                    up_cnt[c] = '0;
                    up_tot[c] = (fwd > 255) ? 8'd255 : fwd[7:0];
                    up_step[c] = step_of(int'(it.level_end) - int'(it.level_begin), up_tot[c]);
                    dn_cnt[c] = '0;
                    dn_tot[c] = (rev > 255) ? 8'd255 : rev[7:0];
                    dn_step[c] = step_of(int'(it.level_begin) - int'(it.level_end), dn_tot[c]);
                    ch_hold_end[c] = it.half_end;
                end
                CMD_STOP: begin
                    ch_active[c] = 1'b0;
                    o = '0;
                    o.out_channel = it.channel;
                    o.pulse = ch_hold_end[c] ? ch_end[c] : ch_begin[c];
                    outs.push_back(o);
                end
                default: begin
                    ch_active[c] = 1'b0;
                    o = '0;
                    o.out_channel = it.channel;
                    o.pulse = it.force_level;
                    outs.push_back(o);
                end
            endcase
            idle = 1'b1;
            for (int k = 0; k < NCH; k++)
                if (ch_active[k])
                    idle = 1'b0;
            foreach (outs[i]) begin
                outs[i].all_idle = idle;
                outs[i].last = (i == outs.size() - 1);
                expected_pulses.push_back(outs[i]);
            end
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        begin
            errors++;
            $display("mismatch %s: got %0d expected %0d (result %0d)", what, got, want,
                     pulses_seen);
        end
    endtask

    function automatic item_in_t make_item(cmd_t op, int ch);
        item_in_t it;
        it.cmd = op;
        it.channel = ch[2:0];
        it.level_begin = 16'($urandom);
        it.level_end = 16'($urandom);
        // mostly short intervals so ramps turn around often
        it.interval_ms = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 200));
        it.rise_pct = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 100));
        it.half_end = 1'($urandom);
        it.force_level = 16'($urandom);
        return it;
    endfunction

    // driver: bursts and gaps, pauses for the configuration phases
    int gap_left;
    int burst_left;
    int launch_mark;
    bit hold_off;
    always @(negedge clk) begin
        if (!rst_n) begin
            start <= 1'b0;
        end
        else if (start) begin
            // hold the item until the monitor has seen it taken
            if (items_sent != launch_mark)
                start <= 1'b0;
        end
        else if (!hold_off && pending_items.size() > 0) begin
            if (gap_left > 0)
                gap_left--;
            else begin
                item <= pending_items[0];
                start <= 1'b1;
                launch_mark = items_sent;
                if (burst_left > 0)
                    burst_left--;
                else begin
                    burst_left = $urandom_range(0, 10);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                end
            end
        end
    end

    // monitor: acceptance and result checking at the rising edge
    always @(posedge clk) begin
        if (rst_n) begin
            cycles++;
            if (start && !busy) begin
                predict_item(pending_items.pop_front());
                items_sent++;
            end
            if (cfg_valid && cfg_ready)
                period_ms = cfg_data;
            if (result_valid) begin
                pulses_seen++;
                if (expected_pulses.size() == 0) begin
                    errors++;
                    $display("unexpected result on channel %0d", result.out_channel);
                end
                else begin
                    item_out_t w;
                    w = expected_pulses.pop_front();
                    if (result.out_channel !== w.out_channel)
                        report_mismatch("out_channel", result.out_channel, w.out_channel);
                    if (result.pulse !== w.pulse)
                        report_mismatch("pulse", result.pulse, w.pulse);
                    if (result.last !== w.last)
                        report_mismatch("last", result.last, w.last);
                    if (result.all_idle !== w.all_idle)
                        report_mismatch("all_idle", result.all_idle, w.all_idle);
                end
            end
            if (cycles > CYCLE_LIMIT) begin
                $display("timeout after %0d cycles", cycles);
                $display("FAILURE");
                $finish;
            end
        end
    end

    task automatic wait_drained();
        begin
            while (pending_items.size() > 0 || start || busy || expected_pulses.size() > 0)
                @(posedge clk);
            repeat (200) @(posedge clk);
        end
    endtask

    task automatic write_period(input logic [9:0] v);
        begin
            wait_drained();
            hold_off = 1'b1;
            @(negedge clk);
            cfg_data <= v;
            cfg_valid <= 1'b1;
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            @(negedge clk);
            cfg_valid <= 1'b0;
            hold_off = 1'b0;
        end
    endtask

    task automatic random_phase(input int n);
        int r;
        begin
            for (int i = 0; i < n; i++) begin
                r = $urandom_range(0, 9);
                if (r < 5)
                    pending_items.push_back(make_item(CMD_TICK, $urandom_range(0, 7)));
                else if (r < 8)
                    pending_items.push_back(make_item(CMD_START, $urandom_range(0, 7)));
                else if (r < 9)
                    pending_items.push_back(make_item(CMD_STOP, $urandom_range(0, 7)));
                else
                    pending_items.push_back(make_item(CMD_FORCE, $urandom_range(0, 7)));
            end
        end
    endtask

    initial begin
        item_in_t it;
        clk = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        item = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        hold_off = 1'b0;
        gap_left = 0;
        burst_left = 0;
        launch_mark = 0;
        errors = 0;
        items_sent = 0;
        pulses_seen = 0;
        cycles = 0;
        period_ms = 10'(PERIOD_RESET);
        for (int k = 0; k < NCH; k++) begin
            ch_active[k] = '0; ch_rising[k] = '0; ch_begin[k] = '0; ch_end[k] = '0;
            ch_level[k] = '0; up_cnt[k] = '0; up_tot[k] = '0; up_step[k] = '0;
            dn_cnt[k] = '0; dn_tot[k] = '0; dn_step[k] = '0; ch_hold_end[k] = '0;
        end
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: stop of a never started channel, tick with nothing active
        pending_items.push_back(make_item(CMD_STOP, 3));
        pending_items.push_back(make_item(CMD_TICK, 0));
        // extremes: full span up and down, zero interval, duty 0, 100, 255
        it = make_item(CMD_START, 0);
        it.level_begin = 16'h0000; it.level_end = 16'hFFFF;
        it.interval_ms = 16'd0; it.rise_pct = 8'd255; it.half_end = 1'b1;
        pending_items.push_back(it);
        it = make_item(CMD_START, 7);
        it.level_begin = 16'hFFFF; it.level_end = 16'h0000;
        it.interval_ms = 16'hFFFF; it.rise_pct = 8'd0; it.half_end = 1'b0;
        pending_items.push_back(it);
        it = make_item(CMD_START, 5);
        it.interval_ms = 16'd45; it.rise_pct = 8'd100;
        pending_items.push_back(it);
        it = make_item(CMD_START, 2);
        it.interval_ms = 16'd60; it.rise_pct = 8'd50;
        pending_items.push_back(it);
        repeat (8) pending_items.push_back(make_item(CMD_TICK, 0));
        pending_items.push_back(make_item(CMD_STOP, 0));
        pending_items.push_back(make_item(CMD_STOP, 7));
        it = make_item(CMD_FORCE, 5); it.force_level = 16'hFFFF;
        pending_items.push_back(it);
        it = make_item(CMD_FORCE, 2); it.force_level = 16'h0000;
        pending_items.push_back(it);
        pending_items.push_back(make_item(CMD_TICK, 0));

        // register settings: extremes, zero treated as one, reset value back
        write_period(10'd0);
        random_phase(30);
        write_period(10'd1);
        random_phase(40);
        write_period(10'h3FF);
        random_phase(20);
        write_period(10'd3);
        random_phase(40);
        write_period(10'd10);
        random_phase(20);
        wait_drained();

        $display("ran %0d items, checked %0d results over tick periods 0, 1, 1023, 3, 10",
                 items_sent, pulses_seen);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
